// ===== src/pbp_pkg.sv =====
// shared constants and types for the perceptron branch predictor
// used by pbp_front, pbp_back, the top module and the testbench; no dependencies
package pbp_pkg;

   localparam int HIST_LEN_DEF      = 62;
   localparam int TABLE_ENTRIES_DEF = 1024;
   localparam int WEIGHT_BITS_DEF   = 8;

   localparam int ADDR_W      = 48;
   localparam int THRESH_W    = 13;
   localparam int SUM_OUT_W   = 14;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int GROUP_SIZE  = 8;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd133;

   // register index decoded from paddr[2]
   localparam logic REG_TRAIN_THRESHOLD = 1'b0;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_GROUP,
      BK_TOTAL,
      BK_UPDATE
   } back_state_type;

endpackage

// ===== src/pbp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module pbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pbp_queue.sv =====
// two-entry queue between the front and the back
// no dependencies
module pbp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             head_ff, head_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;
   logic             tail;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign tail    = head_ff ^ count_ff[0];
   assign rdata   = entry_ff[head_ff];

   // pointer and count
   always_comb begin
      head_in  = do_pop ? ~head_ff : head_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail] <= wdata;
      end
   end

endmodule

// ===== src/pbp_front.sv =====
// front end: accepts items and reduces the address to a table row
// depends on pbp_pkg and pbp_queue (the queue it feeds)
module pbp_front
   import pbp_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [ADDR_W-1:0]                req_branch_address,
   input  logic                             req_taken,
   input  logic                             q_pop,
   output logic [$clog2(TABLE_ENTRIES)-1:0] q_row,
   output logic                             q_taken,
   output logic                             q_empty
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic             q_push, q_full;
   logic [IDX_W:0]   q_wdata, q_rdata;

   assign q_row   = q_rdata[IDX_W:1];
   assign q_taken = q_rdata[0];

   pbp_queue #(.WIDTH(IDX_W + 1)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   generate
      if ((1 << IDX_W) == TABLE_ENTRIES) begin : g_mask
         // row is the low address bits
         assign full    = q_full;
         assign q_push  = push;
         assign q_wdata = {req_branch_address[IDX_W-1:0], req_taken};
      end else begin : g_mod
         localparam int RW = IDX_W + 4;
         localparam int NDIG = ADDR_W / 4;

         logic [ADDR_W-1:0] addr_ff, addr_in;
         logic              taken_ff, taken_in;
         logic [IDX_W-1:0]  rem_ff, rem_in;
         logic [3:0]        cnt_ff, cnt_in;
         logic              busy_ff, busy_in;
         logic [RW-1:0]     v;
         logic              done;

         assign done    = busy_ff && (cnt_ff == 4'(NDIG));
         assign full    = busy_ff;
         assign q_push  = done;
         assign q_wdata = {rem_ff, taken_ff};

         // one hex digit a cycle: rem = (rem*16 + digit) mod entries
         always_comb begin
            v = {rem_ff, addr_ff[ADDR_W-1 -: 4]};
            for (int s = 3; s >= 0; s--) begin
               if (v >= RW'(TABLE_ENTRIES << s)) begin
                  v = v - RW'(TABLE_ENTRIES << s);
               end
            end
            addr_in  = addr_ff;
            taken_in = taken_ff;
            rem_in   = rem_ff;
            cnt_in   = cnt_ff;
            busy_in  = busy_ff;
            if (!busy_ff) begin
               if (push) begin
                  addr_in  = req_branch_address;
                  taken_in = req_taken;
                  rem_in   = '0;
                  cnt_in   = 4'd0;
                  busy_in  = 1'b1;
               end
            end else if (!done) begin
               addr_in = {addr_ff[ADDR_W-5:0], 4'd0};
               rem_in  = v[IDX_W-1:0];
               cnt_in  = cnt_ff + 4'd1;
            end else if (!q_full) begin
               busy_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               cnt_ff  <= 4'd0;
            end else begin
               busy_ff <= busy_in;
               cnt_ff  <= cnt_in;
            end
            addr_ff  <= addr_in;
            taken_ff <= taken_in;
            rem_ff   <= rem_in;
         end
      end
   endgenerate

endmodule

// ===== src/pbp_back.sv =====
// back end: weight row read, dot product, training, history and result register
// depends on pbp_pkg and pbp_ram
module pbp_back
   import pbp_pkg::*;
#(
   parameter int HIST_LEN      = HIST_LEN_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [THRESH_W-1:0]              train_threshold,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] q_row,
   input  logic                             q_taken,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  logic                             pop,
   output logic                             empty,
   output logic                             rsp_predicted_taken,
   output logic signed [SUM_OUT_W-1:0]      rsp_perceptron_sum,
   output logic                             rsp_mispredicted,
   output logic                             rsp_trained
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int ROW_W  = HIST_LEN * WEIGHT_BITS;
   localparam int WMAX   = (1 << (WEIGHT_BITS - 1)) - 1;
   localparam int SUM_W  = $clog2(HIST_LEN * WMAX + 1) + 1;
   localparam int NG     = (HIST_LEN + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int CW     = ((SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W) + 1;
   localparam int SAT_HI = (1 << (SUM_OUT_W - 1)) - 1;
   localparam int SAT_LO = -(1 << (SUM_OUT_W - 1));

   back_state_type state_ff, state_in;

   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic              taken_ff, taken_in;
   logic [HIST_LEN-2:0] hist_ff, hist_in;
   logic signed [SUM_W-1:0] grp_ff [NG];
   logic signed [SUM_W-1:0] grp_in [NG];
   logic signed [SUM_W-1:0] total_ff, total_in;

   logic              out_valid_ff, out_valid_in;
   logic              pred_ff, pred_in;
   logic signed [SUM_OUT_W-1:0] shown_ff, shown_in;
   logic              miss_ff, miss_in;
   logic              train_ff, train_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ROW_W-1:0]  wr_data, rd_data, reset_row, new_row;
   logic signed [SUM_W-1:0] term [HIST_LEN];
   logic [HIST_LEN-1:0] xbit;
   logic signed [SUM_W-1:0] mag;
   logic signed [CW-1:0] wide_sum;
   logic              pred, miss, train, out_free;

   pbp_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_weights (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_row),
      .rd_data (rd_data)
   );

   // bipolar inputs and signed terms of the dot product
   always_comb begin
      xbit = {hist_ff, 1'b1};
      reset_row = '0;
      reset_row[0] = 1'b1;
      for (int j = 0; j < HIST_LEN; j++) begin
         if (xbit[j]) begin
            term[j] = SUM_W'(signed'(rd_data[j*WEIGHT_BITS +: WEIGHT_BITS]));
         end else begin
            term[j] = -SUM_W'(signed'(rd_data[j*WEIGHT_BITS +: WEIGHT_BITS]));
         end
      end
   end

   // partial sums of up to eight terms each, and the total of the registered partial sums
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < HIST_LEN) begin
               grp_in[g] = grp_in[g] + term[g * GROUP_SIZE + k];
            end
         end
      end
      total_in = '0;
      for (int g = 0; g < NG; g++) begin
         total_in = total_in + grp_ff[g];
      end
   end

   // prediction, training decision, saturated shown sum and trained row
   always_comb begin
      logic signed [WEIGHT_BITS:0] w, nw;
      pred = total_ff > 0;
      miss = pred != taken_ff;
      mag  = (total_ff < 0) ? -total_ff : total_ff;
      train = miss || (CW'(mag) <= CW'(train_threshold));
      wide_sum = CW'(total_ff);
      if (wide_sum > CW'(SAT_HI)) begin
         shown_in = SUM_OUT_W'(SAT_HI);
      end else if (wide_sum < CW'(SAT_LO)) begin
         shown_in = SUM_OUT_W'(SAT_LO);
      end else begin
         shown_in = wide_sum[SUM_OUT_W-1:0];
      end
      for (int j = 0; j < HIST_LEN; j++) begin
         w = (WEIGHT_BITS+1)'(signed'(rd_data[j*WEIGHT_BITS +: WEIGHT_BITS]));
         nw = (taken_ff == xbit[j]) ? w + 2'sd1 : w - 2'sd1;
         if (nw > (WEIGHT_BITS+1)'(WMAX)) begin
            nw = (WEIGHT_BITS+1)'(WMAX);
         end else if (nw < -(WEIGHT_BITS+1)'(WMAX)) begin
            nw = -(WEIGHT_BITS+1)'(WMAX);
         end
         new_row[j*WEIGHT_BITS +: WEIGHT_BITS] = nw[WEIGHT_BITS-1:0];
      end
   end

   // sequencer: clear pass, read, group sums, total, writeback
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      row_in       = row_ff;
      taken_in     = taken_ff;
      hist_in      = hist_ff;
      out_valid_in = out_valid_ff && !pop;
      pred_in      = pred_ff;
      miss_in      = miss_ff;
      train_in     = train_ff;
      out_free     = !out_valid_ff || pop;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = new_row;
      rd_en        = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = reset_row;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               rd_en    = 1'b1;
               q_pop    = 1'b1;
               row_in   = q_row;
               taken_in = q_taken;
               state_in = BK_GROUP;
            end
         end
         BK_GROUP: begin
            state_in = BK_TOTAL;
         end
         BK_TOTAL: begin
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (out_free) begin
               wr_en        = train;
               out_valid_in = 1'b1;
               pred_in      = pred;
               miss_in      = miss;
               train_in     = train;
               hist_in      = {hist_ff[HIST_LEN-3:0], taken_ff};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         hist_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         hist_ff      <= hist_in;
         out_valid_ff <= out_valid_in;
      end
      row_ff   <= row_in;
      taken_ff <= taken_in;
      grp_ff   <= grp_in;
      total_ff <= total_in;
      pred_ff  <= pred_in;
      miss_ff  <= miss_in;
      train_ff <= train_in;
      if (state_ff == BK_UPDATE && out_free) begin
         shown_ff <= shown_in;
      end
   end

   assign empty               = !out_valid_ff;
   assign rsp_predicted_taken = pred_ff;
   assign rsp_perceptron_sum  = shown_ff;
   assign rsp_mispredicted    = miss_ff;
   assign rsp_trained         = train_ff;

   // checks
   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == BK_UPDATE)
      else $error("result appeared outside writeback");
   a_miss_trains: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && miss_ff |-> train_ff)
      else $error("mispredicted item not trained");
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == BK_CLEAR || state_ff == BK_UPDATE))
      else $error("weight write outside clear or writeback");
   a_no_read_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_CLEAR |-> !q_pop)
      else $error("item taken during clear pass");

endmodule

// ===== src/perceptron_branch_predictor_unit.sv =====
// Perceptron branch predictor with global history. After reset the weight table
// is initialised by a clear pass over all TABLE_ENTRIES rows, during which the
// back takes no item. The front uses the low address bits as the row when
// TABLE_ENTRIES is a power of two, else it reduces the address modulo
// TABLE_ENTRIES one hex digit a cycle and takes no new item until that row is
// queued. The back handles one item at a time: row read, partial sums of up to
// eight terms, final sum, then training writeback with the result, which waits
// for the previous result to be popped. train_threshold is at apb byte address 0.
// depends on pbp_pkg, pbp_front, pbp_back
module perceptron_branch_predictor_unit
   import pbp_pkg::*;
#(
   parameter int HIST_LEN      = HIST_LEN_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [ADDR_W-1:0]           req_branch_address,
   input  logic                        req_taken,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_predicted_taken,
   output logic signed [SUM_OUT_W-1:0] rsp_perceptron_sum,
   output logic                        rsp_mispredicted,
   output logic                        rsp_trained,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_W-1:0]       paddr,
   input  logic [CSR_DATA_W-1:0]       pwdata,
   output logic [CSR_DATA_W-1:0]       prdata,
   output logic                        pready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [IDX_W-1:0]    q_row;
   logic                q_taken, q_empty, q_pop;

   // configuration register
   assign pready = 1'b1;
   always_comb begin
      thresh_in = thresh_ff;
      if (psel && penable && pwrite && paddr[2] == REG_TRAIN_THRESHOLD) begin
         thresh_in = pwdata[THRESH_W-1:0];
      end
      prdata = '0;
      if (paddr[2] == REG_TRAIN_THRESHOLD) begin
         prdata = CSR_DATA_W'(thresh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   pbp_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_branch_address (req_branch_address),
      .req_taken          (req_taken),
      .q_pop              (q_pop),
      .q_row              (q_row),
      .q_taken            (q_taken),
      .q_empty            (q_empty)
   );

   pbp_back #(
      .HIST_LEN      (HIST_LEN),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .train_threshold     (thresh_ff),
      .q_row               (q_row),
      .q_taken             (q_taken),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .pop                 (pop),
      .empty               (empty),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_perceptron_sum  (rsp_perceptron_sum),
      .rsp_mispredicted    (rsp_mispredicted),
      .rsp_trained         (rsp_trained)
   );

endmodule

// ===== tb/perceptron_branch_predictor_unit_test.sv =====
// self-checking testbench for perceptron_branch_predictor_unit: a directed table, then
// random branch traces checked against a behavioral perceptron model kept in the bench
// depends on pbp_pkg and perceptron_branch_predictor_unit
`timescale 1ns / 100ps

module perceptron_branch_predictor_unit_test;
   import pbp_pkg::*;

   localparam int HIST_LEN      = HIST_LEN_DEF;
   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int WMAX          = (1 << (WEIGHT_BITS_DEF - 1)) - 1;
   localparam int STALL_LIMIT   = 6000;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_HOT       = 8;

   typedef struct packed {
      logic                        pred;
      logic signed [SUM_OUT_W-1:0] sum;
      logic                        miss;
      logic                        trn;
   } branch_result_type;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic              tk;
      bit                typed;
      branch_result_type res;
   } branch_row_type;

   logic                        clock, reset;
   logic                        push, full, empty, pop;
   logic [ADDR_W-1:0]           req_branch_address;
   logic                        req_taken;
   logic                        rsp_predicted_taken;
   logic signed [SUM_OUT_W-1:0] rsp_perceptron_sum;
   logic                        rsp_mispredicted, rsp_trained;
   logic                        psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0]       paddr;
   logic [CSR_DATA_W-1:0]       pwdata, prdata;
   logic                        pready;

   // model state
   int                  weights [TABLE_ENTRIES][HIST_LEN];
   logic [HIST_LEN-2:0] history;
   logic [THRESH_W-1:0] threshold;

   branch_result_type outcome_queue[$];
   int  errors;
   int  received;
   bit  send_burst, recv_burst;
   bit  finished;

   perceptron_branch_predictor_unit u_dut (
      .clock, .reset, .push, .full, .req_branch_address, .req_taken,
      .empty, .pop, .rsp_predicted_taken, .rsp_perceptron_sum,
      .rsp_mispredicted, .rsp_trained,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void reset_model();
      for (int r = 0; r < TABLE_ENTRIES; r++)
         for (int i = 0; i < HIST_LEN; i++)
            weights[r][i] = (i == 0) ? 1 : 0;
      history   = '0;
      threshold = THRESH_RESET;
   endfunction

   // dot product, prediction, training and history update of one resolved branch
   function automatic branch_result_type predict_branch(logic [ADDR_W-1:0] addr, logic tk);
      branch_result_type r;
      int row, total, mag, step, x, w;
      row   = int'(addr % TABLE_ENTRIES);
      total = weights[row][0];
      for (int i = 1; i < HIST_LEN; i++)
         total += history[i-1] ? weights[row][i] : -weights[row][i];
      r.pred = (total > 0);
      r.miss = (r.pred != tk);
      mag    = (total < 0) ? -total : total;
      r.trn  = r.miss || (mag <= int'(threshold));
      if (r.trn) begin
         step = tk ? 1 : -1;
         for (int i = 0; i < HIST_LEN; i++) begin
            x = (i == 0) ? 1 : (history[i-1] ? 1 : -1);
            w = weights[row][i] + step * x;
            if (w > WMAX) w = WMAX;
            if (w < -WMAX) w = -WMAX;
            weights[row][i] = w;
         end
      end
      history = {history[HIST_LEN-3:0], tk};
      if (total > 8191) total = 8191;
      if (total < -8192) total = -8192;
      r.sum = total[SUM_OUT_W-1:0];
      return r;
   endfunction

   task automatic report(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endtask

   // register write: setup phase, then access phase
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr[2] == REG_TRAIN_THRESHOLD) threshold = data[THRESH_W-1:0];
   endtask

   // offer one item, wait for acceptance, then queue its expected outcome
   task automatic send_branch(logic [ADDR_W-1:0] addr, logic tk, bit typed,
                              branch_result_type typed_res);
      int gap;
      branch_result_type r;
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_branch_address <= addr;
      req_taken          <= tk;
      @(posedge clock);
      while (full) @(posedge clock);
      r = predict_branch(addr, tk);
      outcome_queue.push_back(typed ? typed_res : r);
   endtask

   task automatic drain_idle();
      push <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // receiver: random gaps, bursts, and one long hold-off to fill the block
   initial begin
      int  gap;
      bit  held;
      pop  = 1'b0;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (received % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
         gap = recv_burst ? 0 : $urandom_range(0, 19);
         if (!held && received == 100) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         received++;
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      branch_result_type e;
      if (!reset && pop && !empty) begin
         if (outcome_queue.size() == 0) begin
            report("result with nothing expected");
         end else begin
            e = outcome_queue.pop_front();
            if (rsp_predicted_taken !== e.pred)
               report($sformatf("predicted_taken exp %0d got %0d", e.pred, rsp_predicted_taken));
            if (rsp_perceptron_sum !== e.sum)
               report($sformatf("perceptron_sum exp %0d got %0d", e.sum, rsp_perceptron_sum));
            if (rsp_mispredicted !== e.miss)
               report($sformatf("mispredicted exp %0d got %0d", e.miss, rsp_mispredicted));
            if (rsp_trained !== e.trn)
               report($sformatf("trained exp %0d got %0d", e.trn, rsp_trained));
         end
      end
   end

   // watchdog on cycles with no item moving
   initial begin
      int idle_count;
      idle_count = 0;
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_count = 0;
         else idle_count++;
         if (idle_count >= STALL_LIMIT && !finished) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      branch_row_type    dir_rows[$];
      branch_row_type    row;
      branch_result_type none;
      logic [ADDR_W-1:0] hot_addr [NUM_HOT];
      int                hot_period [NUM_HOT];
      int                hot_count [NUM_HOT];
      int                thresholds [6];
      int                k, n;
      logic              tk;
      logic [ADDR_W-1:0] addr;

      errors = 0; received = 0; finished = 0;
      send_burst = 0; recv_burst = 0;
      none = '0;
      reset = 1'b1; push = 1'b0; req_branch_address = '0; req_taken = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      csr_write(3'd0, 32'd133);

      // fresh rows hold only the bias weight, so the sum is one
      dir_rows = '{
         '{48'h0,            1'b1, 1, '{1'b1, 14'sd1, 1'b0, 1'b1}},
         '{48'hFFFF_FFFF_FFFF, 1'b0, 1, '{1'b1, 14'sd1, 1'b1, 1'b1}},
         '{48'h8000_0000_0001, 1'b1, 1, '{1'b1, 14'sd1, 1'b0, 1'b1}},
         '{48'h5555_5555_5555, 1'b0, 1, '{1'b1, 14'sd1, 1'b1, 1'b1}},
         '{48'hAAAA_AAAA_AAAA, 1'b1, 1, '{1'b1, 14'sd1, 1'b0, 1'b1}},
         '{48'h0000_0000_0200, 1'b0, 1, '{1'b1, 14'sd1, 1'b1, 1'b1}},
         '{48'h0,            1'b0, 0, none},
         '{48'h0,            1'b0, 0, none},
         '{48'hFFFF_FFFF_FFFF, 1'b1, 0, none},
         '{48'h1234_5678_9C00, 1'b0, 0, none},
         '{48'h0,            1'b1, 0, none},
         '{48'h7FFF_FFFF_FFFF, 1'b1, 0, none},
         '{48'h0000_0000_0400, 1'b1, 0, none},
         '{48'h5555_5555_5555, 1'b1, 0, none},
         '{48'hAAAA_AAAA_AAAA, 1'b0, 0, none}
      };
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_branch(row.addr, row.tk, row.typed, row.res);
      end
      drain_idle();

      // threshold settings per phase, extremes and the reset value among them
      thresholds = '{0, 8191, -1, 133, -1, 8191};
      for (int p = 0; p < 6; p++) begin
         if (thresholds[p] < 0) csr_write(3'd0, $urandom());
         else csr_write(3'd0, thresholds[p]);
         if (p == 2) csr_write(3'd4, $urandom());   // no register there
         for (int h = 0; h < NUM_HOT; h++) begin
            hot_addr[h]   = ADDR_W'({$urandom(), $urandom()});
            hot_period[h] = $urandom_range(1, 9);
            hot_count[h]  = 0;
         end
         n = (p == 5) ? 300 : 120;
         for (int j = 0; j < n; j++) begin
            if (j % 30 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if (p == 5) begin
               // one row driven steadily taken until its weights saturate
               addr = hot_addr[0];
               tk   = 1'b1;
            end else if ($urandom_range(0, 9) < 8) begin
               // looping branches with a fixed period, high bits varying
               k    = $urandom_range(0, NUM_HOT - 1);
               addr = ADDR_W'({$urandom(), $urandom()});
               addr[9:0] = hot_addr[k][9:0];
               tk   = (hot_count[k] % hot_period[k]) != 0;
               if ($urandom_range(0, 19) == 0) tk = ~tk;
               hot_count[k]++;
            end else begin
               addr = ADDR_W'({$urandom(), $urandom()});
               tk   = 1'($urandom_range(0, 1));
            end
            send_branch(addr, tk, 0, none);
         end
         send_burst = 0;
         if (p == 5) send_branch(hot_addr[0], 1'b0, 0, none);
         drain_idle();
      end

      finished = 1;
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== perceptron_branch_predictor_unit.f =====
src/pbp_pkg.sv
src/pbp_ram.sv
src/pbp_queue.sv
src/pbp_front.sv
src/pbp_back.sv
src/perceptron_branch_predictor_unit.sv
tb/perceptron_branch_predictor_unit_test.sv
